// ===== rtl/beq_pkg.sv =====
// Package for the button event qualifier.
// Holds operation codes, register indexes and the shared struct types; no dependencies.
`default_nettype none
package beq_pkg;

  typedef enum logic [1:0] {
    FUNC_CHECK   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_RESYNC  = 2'd2
  } func_t;

  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_REPEAT     = 2'd2;
  localparam logic [1:0] REG_SWAP       = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd10;
  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [15:0] REPEAT_RST     = 16'd100;

  localparam int BTN_DOWN = 0;
  localparam int BTN_PUSH = 1;
  localparam int BTN_UP   = 2;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic [15:0] long_press_time;
    logic [15:0] repeat_period;
    logic        swap_levers;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  prev_buttons;
    logic [31:0] change_time;
    logic [31:0] next_repeat_time;
  } state_t;

  typedef struct packed {
    logic done_res;
    logic evt_click;
    logic evt_up;
    logic evt_dn;
    logic evt_long;
    logic evt_auto;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/beq_cfg_regs.sv =====
// Configuration register file of the button event qualifier.
// Depends on beq_pkg for the register indexes, reset values and cfg_t.
`default_nettype none
module beq_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output beq_pkg::cfg_t      cfg
);
  import beq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg_nxt.debounce_time   = cfg_data;
        REG_LONG_PRESS: cfg_nxt.long_press_time = cfg_data;
        REG_REPEAT:     cfg_nxt.repeat_period   = cfg_data;
        REG_SWAP:       cfg_nxt.swap_levers     = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DEBOUNCE_RST;
      cfg_r.long_press_time <= LONG_PRESS_RST;
      cfg_r.repeat_period   <= REPEAT_RST;
      cfg_r.swap_levers     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/beq_eval.sv =====
// Evaluation logic for one poll: result fields and the next qualifier state.
// Depends on beq_pkg for func_t, cfg_t, state_t and result_t.
`default_nettype none
module beq_eval (
  input  wire beq_pkg::cfg_t    cfg,
  input  wire beq_pkg::state_t  state,
  input  wire logic [1:0]       func,
  input  wire logic [31:0]      now_time,
  input  wire logic [2:0]       buttons,
  output beq_pkg::result_t      res,
  output beq_pkg::state_t       state_nxt
);
  import beq_pkg::*;

  logic [2:0]  cur;
  logic [2:0]  changed;
  logic [2:0]  rise;
  logic [31:0] dt;
  logic [31:0] long_ext;
  logic        past_long;
  logic        beyond_long;

  always_comb begin
    cur = buttons;
    if (cfg.swap_levers && (buttons[BTN_DOWN] != buttons[BTN_UP])) begin
      cur = buttons ^ 3'b101;
    end
    changed     = state.prev_buttons ^ cur;
    rise        = changed & cur;
    dt          = now_time - state.change_time;
    long_ext    = {16'd0, cfg.long_press_time};
    past_long   = (dt >= long_ext);
    beyond_long = (dt > long_ext);

    res       = '0;
    state_nxt = state;
    case (func)
      FUNC_CHECK: begin
        if (dt > {16'd0, cfg.debounce_time}) begin
          res.evt_click          = rise[BTN_PUSH];
          res.evt_up             = rise[BTN_UP];
          res.evt_dn             = rise[BTN_DOWN];
          res.done_res           = 1'b1;
          state_nxt.prev_buttons = cur;
          state_nxt.change_time  = now_time;
        end
      end
      FUNC_RELEASE: begin
        if (past_long && cur[BTN_PUSH]) begin
          res.evt_long = 1'b1;
          res.done_res = 1'b1;
        end else if (changed[BTN_PUSH]) begin
          res.evt_click = 1'b1;
          res.done_res  = 1'b1;
        end else if (changed != 3'd0) begin
          state_nxt.prev_buttons = cur;
          state_nxt.change_time  = now_time;
          res.done_res           = 1'b1;
        end else if (beyond_long && (now_time > state.next_repeat_time)) begin
          res.evt_dn     = cur[BTN_DOWN];
          res.evt_up     = cur[BTN_UP];
          res.evt_auto   = cur[BTN_DOWN] | cur[BTN_UP];
          res.done_res   = 1'b1;
          state_nxt.next_repeat_time = now_time + {16'd0, cfg.repeat_period};
        end
      end
      FUNC_RESYNC: begin
        state_nxt.prev_buttons     = buttons;
        state_nxt.change_time      = now_time;
        state_nxt.next_repeat_time = now_time;
        res.done_res               = 1'b1;
      end
      default: begin
        res       = '0;
        state_nxt = state;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/button_event_qualifier_core.sv =====
// Button event qualifier: top level with input register, state and result register.
// Depends on beq_pkg, beq_cfg_regs and beq_eval.
//
// Usage: each input item is one poll carrying an operation code, the current
// tick count and a three-button sample. Every item yields exactly one result
// item with a done flag and the event bits. Both data channels use valid and
// stall; an item moves at a clock edge where valid is high and stall is low.
// The configuration channel writes one register per valid and ready edge and
// is always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. An accepted item is held in the input
// register; the evaluation logic then updates the qualifier state and loads
// the result register at the same edge. Throughput is one item per cycle
// while the receiver does not stall, set by the single evaluation stage whose
// state is updated in the same cycle the next item reads it.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; after that in_stall rises.
// Synchronous reset loads the register defaults, clears the qualifier state
// and empties both registers.
`default_nettype none
module button_event_qualifier_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_now_time,
  input  wire logic [2:0]  in_buttons,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_done_res,
  output logic             out_evt_click,
  output logic             out_evt_up,
  output logic             out_evt_dn,
  output logic             out_evt_long,
  output logic             out_evt_auto,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import beq_pkg::*;

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  result_t res;
  result_t res_r;

  logic        s1_valid_r;
  logic [1:0]  s1_func_r;
  logic [31:0] s1_now_r;
  logic [2:0]  s1_buttons_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;

  beq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  beq_eval u_eval (
    .cfg       (cfg),
    .state     (state_r),
    .func      (s1_func_r),
    .now_time  (s1_now_r),
    .buttons   (s1_buttons_r),
    .res       (res),
    .state_nxt (state_nxt)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r    <= in_func;
      s1_now_r     <= in_now_time;
      s1_buttons_r <= in_buttons;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_done_res   = res_r.done_res;
  assign out_evt_click  = res_r.evt_click;
  assign out_evt_up     = res_r.evt_up;
  assign out_evt_dn     = res_r.evt_dn;
  assign out_evt_long   = res_r.evt_long;
  assign out_evt_auto   = res_r.evt_auto;

`ifndef SYNTHESIS
  a_repeat_has_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evt_auto |-> (out_evt_up || out_evt_dn))
    else $error("repeat flag without up or down event");

  a_event_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_evt_click || out_evt_up || out_evt_dn || out_evt_long)
    |-> out_done_res)
    else $error("event reported without done flag");

  a_long_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evt_long
    |-> !(out_evt_click || out_evt_up || out_evt_dn || out_evt_auto))
    else $error("long press reported together with another event");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free slot");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_button_event_qualifier_core.sv =====
// Self-checking testbench for button_event_qualifier_core: random and directed polls
// with a built-in predictor of the debounce, click, long-press and auto-repeat logic.
// Depends on beq_pkg and the RTL of the core; needs no files or arguments.
`timescale 1ns / 1ps
module tb_button_event_qualifier_core;
  import beq_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] tick;
    logic [2:0]  btns;
  } poll_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [31:0] in_now_time = '0;
  logic [2:0]  in_buttons = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_done_res;
  logic        out_evt_click;
  logic        out_evt_up;
  logic        out_evt_dn;
  logic        out_evt_long;
  logic        out_evt_auto;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  button_event_qualifier_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_now_time(in_now_time), .in_buttons(in_buttons),
    .out_valid(out_valid), .out_stall(out_stall), .out_done_res(out_done_res),
    .out_evt_click(out_evt_click), .out_evt_up(out_evt_up), .out_evt_dn(out_evt_dn),
    .out_evt_long(out_evt_long), .out_evt_auto(out_evt_auto),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t    model_cfg = '{debounce_time: DEBOUNCE_RST, long_press_time: LONG_PRESS_RST,
                         repeat_period: REPEAT_RST, swap_levers: 1'b0};
  state_t  model_state = '0;
  poll_t   pending_polls[$];
  result_t expected_events[$];
  poll_t   driven_poll;
  logic [31:0] gen_tick = '0;
  int      gen_count = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t qualify_poll(poll_t p);
    result_t     r;
    logic [2:0]  cur;
    logic [2:0]  diff;
    logic [31:0] dt;
    r = '0;
    cur = p.btns;
    if (model_cfg.swap_levers) begin
      cur[BTN_UP] = p.btns[BTN_DOWN];
      cur[BTN_DOWN] = p.btns[BTN_UP];
    end
    dt = p.tick - model_state.change_time;
    diff = model_state.prev_buttons ^ cur;
    case (p.op)
      FUNC_CHECK: begin
        if (dt > {16'd0, model_cfg.debounce_time}) begin
          r.evt_click = diff[BTN_PUSH] & cur[BTN_PUSH];
          r.evt_up = diff[BTN_UP] & cur[BTN_UP];
          r.evt_dn = diff[BTN_DOWN] & cur[BTN_DOWN];
          model_state.prev_buttons = cur;
          model_state.change_time = p.tick;
          r.done_res = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (dt >= {16'd0, model_cfg.long_press_time} && cur[BTN_PUSH]) begin
          r.evt_long = 1'b1;
          r.done_res = 1'b1;
        end else if (diff[BTN_PUSH]) begin
          r.evt_click = 1'b1;
          r.done_res = 1'b1;
        end else if (diff != 3'b000) begin
          model_state.prev_buttons = cur;
          model_state.change_time = p.tick;
          r.done_res = 1'b1;
        end else if (dt > {16'd0, model_cfg.long_press_time} &&
                     p.tick > model_state.next_repeat_time) begin
          r.evt_dn = cur[BTN_DOWN];
          r.evt_up = cur[BTN_UP];
          r.evt_auto = cur[BTN_DOWN] | cur[BTN_UP];
          model_state.next_repeat_time = p.tick + {16'd0, model_cfg.repeat_period};
          r.done_res = 1'b1;
        end
      end
      FUNC_RESYNC: begin
        model_state.prev_buttons = p.btns;
        model_state.change_time = p.tick;
        model_state.next_repeat_time = p.tick;
        r.done_res = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string show_events(result_t r);
    return $sformatf("done=%b click=%b up=%b down=%b long=%b repeat=%b",
                     r.done_res, r.evt_click, r.evt_up, r.evt_dn, r.evt_long,
                     r.evt_auto);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_events.push_back(qualify_poll(driven_poll));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_polls.size() != 0) begin
          driven_poll = pending_polls.pop_front();
          in_func <= driven_poll.op;
          in_now_time <= driven_poll.tick;
          in_buttons <= driven_poll.btns;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 4);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_done_res, out_evt_click, out_evt_up, out_evt_dn, out_evt_long,
               out_evt_auto};
        if (expected_events.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result item: %s", show_events(got));
          end
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (got.done_res !== want.done_res || got.evt_click !== want.evt_click ||
              got.evt_up !== want.evt_up || got.evt_dn !== want.evt_dn ||
              got.evt_long !== want.evt_long || got.evt_auto !== want.evt_auto) begin
            if (mismatches < 10) begin
              $display("mismatch at %0t: expected %s, got %s", $realtime,
                       show_events(want), show_events(got));
            end
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_poll(logic [1:0] op, logic [31:0] tick, logic [2:0] btns);
    pending_polls.push_back('{op: op, tick: tick, btns: btns});
    gen_tick = tick;
    if (op != FUNC_UNUSED) begin
      gen_count++;
    end
  endtask

  task automatic write_regs(logic [15:0] deb, logic [15:0] lp, logic [15:0] rp, logic swap);
    logic [15:0] vals[4];
    logic [1:0]  idx[4];
    vals = '{deb, lp, rp, {15'd0, swap}};
    idx = '{REG_DEBOUNCE, REG_LONG_PRESS, REG_REPEAT, REG_SWAP};
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[i])
        REG_DEBOUNCE:   model_cfg.debounce_time = vals[i];
        REG_LONG_PRESS: model_cfg.long_press_time = vals[i];
        REG_REPEAT:     model_cfg.repeat_period = vals[i];
        default:        model_cfg.swap_levers = vals[i][0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_polls.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // A press held through debounce, long press and auto repeat, then released.
  task automatic run_gesture();
    logic [31:0] deb;
    logic [31:0] lp;
    logic [31:0] rp;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] off;
    logic [31:0] step;
    logic [2:0]  held;
    logic [2:0]  b;
    deb = {16'd0, model_cfg.debounce_time};
    lp = {16'd0, model_cfg.long_press_time};
    rp = {16'd0, model_cfg.repeat_period};
    if ($urandom_range(0, 5) == 0) begin
      t0 = 32'hFFFF_FFFF - $urandom_range(0, lp + rp + deb);
    end else begin
      t0 = $urandom;
    end
    add_poll(FUNC_RESYNC, t0, ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000);
    held = 3'($urandom_range(1, 7));
    if ($urandom_range(0, 1) == 1) begin
      add_poll(FUNC_CHECK, t0 + $urandom_range(0, deb), held);
    end
    t1 = t0 + deb + 1 + $urandom_range(0, 2);
    add_poll(FUNC_CHECK, t1, held);
    off = 0;
    repeat ($urandom_range(3, 12)) begin
      case ($urandom_range(0, 5))
        0: step = 1;
        1: step = rp;
        2: step = rp + 1;
        3: step = $urandom_range(0, lp / 2 + 1);
        4: step = (off < lp) ? lp - off - 1 + $urandom_range(0, 2) : 1;
        default: step = $urandom_range(0, rp + 1);
      endcase
      off += step;
      b = ($urandom_range(0, 7) == 0) ? 3'($urandom) : held;
      add_poll(($urandom_range(0, 9) == 0) ? FUNC_CHECK : FUNC_RELEASE, t1 + off, b);
    end
    add_poll(FUNC_RELEASE, t1 + off + 1, 3'b000);
  endtask

  task automatic fill_random(int target);
    gen_count = 0;
    while (gen_count < target) begin
      if ($urandom_range(0, 6) == 0) begin
        add_poll(2'($urandom),
                 ($urandom_range(0, 1) == 1) ? $urandom
                   : gen_tick + $urandom_range(0, 2 * model_cfg.long_press_time + 2),
                 3'($urandom));
      end else begin
        run_gesture();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    add_poll(FUNC_RESYNC, 32'd100, 3'b000);
    add_poll(FUNC_CHECK, 32'd110, 3'b111);
    add_poll(FUNC_CHECK, 32'd111, 3'b111);
    add_poll(FUNC_UNUSED, 32'd200, 3'b111);
    add_poll(FUNC_RELEASE, 32'd610, 3'b111);
    add_poll(FUNC_RELEASE, 32'd611, 3'b111);
    add_poll(FUNC_RELEASE, 32'd612, 3'b101);
    add_poll(FUNC_CHECK, 32'd700, 3'b101);
    add_poll(FUNC_RELEASE, 32'd1200, 3'b101);
    add_poll(FUNC_RELEASE, 32'd1201, 3'b101);
    add_poll(FUNC_RELEASE, 32'd1301, 3'b101);
    add_poll(FUNC_RELEASE, 32'd1302, 3'b101);
    add_poll(FUNC_RELEASE, 32'd1400, 3'b100);
    add_poll(FUNC_RESYNC, 32'hFFFF_FF00, 3'b001);
    add_poll(FUNC_RELEASE, 32'h0000_0100, 3'b001);
    add_poll(FUNC_CHECK, 32'hFFFF_FFFF, 3'b000);
    add_poll(FUNC_CHECK, 32'h0000_0005, 3'b010);
    add_poll(FUNC_CHECK, 32'h0000_000A, 3'b010);
    add_poll(FUNC_RESYNC, 32'hFFFF_FFFF, 3'b111);
    add_poll(FUNC_UNUSED, 32'h0000_0000, 3'b000);
    fill_random(150);
    wait_drained();

    write_regs(16'd0, 16'd0, 16'd0, 1'b1);
    add_poll(FUNC_RESYNC, 32'd1000, 3'b000);
    add_poll(FUNC_CHECK, 32'd1000, 3'b001);
    add_poll(FUNC_CHECK, 32'd1001, 3'b001);
    add_poll(FUNC_RELEASE, 32'd1001, 3'b101);
    add_poll(FUNC_RELEASE, 32'd1002, 3'b100);
    fill_random(200);
    wait_drained();

    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    fill_random(200);
    wait_drained();

    write_regs(16'($urandom_range(0, 20)), 16'($urandom_range(0, 60)),
               16'($urandom_range(0, 30)), 1'b1);
    fill_random(250);
    wait_drained();

    write_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    quiet = 1'b1;
    fill_random(300);
    wait_drained();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
